### hw/rtl/pgfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_pkg
// Shared constants, types and arithmetic helpers of the particle group
// force step block.
// ---------------------------------------------------------------------------
package pgfs_pkg;

  // sizing
  localparam int GROUP_COUNT   = 3;
  localparam int MAX_PER_GROUP = 256;
  localparam int STORE_DEPTH   = GROUP_COUNT * MAX_PER_GROUP;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int IDX_W         = $clog2(MAX_PER_GROUP);
  localparam int CNT_W         = $clog2(MAX_PER_GROUP + 1);
  localparam int GCNT_W        = $clog2(GROUP_COUNT + 1);

  // fixed field widths
  localparam int COORD_W  = 16;
  localparam int ACT_W    = 9;
  localparam int DSQ_W    = 32;
  localparam int ROOT_W   = 16;
  localparam int QUO_W    = 17;
  localparam int NUM_W    = 33;
  // sum of up to MAX_PER_GROUP quotients of at most 2^15 each
  localparam int SUM_W    = $clog2(MAX_PER_GROUP) + QUO_W;
  localparam int VSUM_W   = SUM_W + 1;

  // configuration reset values
  localparam logic [15:0] ARENA_W_RST = 16'd64000;
  localparam logic [15:0] ARENA_H_RST = 16'd64000;
  localparam logic [15:0] CUTOFF_RST  = 16'd5120;
  localparam logic [8:0]  ACTIVE_RST  = 9'd200;

  // request and acknowledge codes
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_RUN   = 2'd2,
    REQ_OTHER = 2'd3
  } req_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ARENA_WIDTH  = 2'd0,
    CFG_ARENA_HEIGHT = 2'd1,
    CFG_CUTOFF       = 2'd2,
    CFG_ACTIVE_COUNT = 2'd3
  } cfg_idx_t;

  // memory address sources
  typedef enum logic [1:0] {
    SEL_REQ   = 2'd0,
    SEL_A     = 2'd1,
    SEL_B     = 2'd2,
    SEL_WALL  = 2'd3
  } addr_sel_t;

  // memory write sources
  typedef enum logic [1:0] {
    WR_REQ   = 2'd0,
    WR_MOVE  = 2'd1,
    WR_WALL  = 2'd2,
    WR_CLEAR = 2'd3
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      latch;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      pos_we;
    logic      vel_we;
    wr_sel_t   wr_sel;
    logic      capture;
    logic      a_latch;
    logic      i_clr;
    logic      i_inc;
    logic      j_inc;
    logic      g_clr;
    logic      g_inc;
    logic      diff;
    logic      mult;
    logic      dsum;
    logic      sqrt_start;
    logic      div_start;
    logic      acc;
    logic      vel_calc;
    logic      clr_inc;
  } pgfs_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t req;
    logic addr_ok;
    logic groups_ok;
    logic i_end;
    logic j_end;
    logic g_end;
    logic clr_last;
    logic in_range;
    logic sqrt_done;
    logic div_done;
  } pgfs_stat_t;

  // flat store address of a particle
  function automatic logic [ADDR_W-1:0] addr_of(input logic [3:0] grp,
                                                input logic [IDX_W-1:0] idx);
    return ADDR_W'(grp) * ADDR_W'(MAX_PER_GROUP) + ADDR_W'(idx);
  endfunction

  // clamp to signed 16 bit
  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) r = 16'h7fff;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  // clamp to unsigned 16 bit
  function automatic logic [15:0] satpos(input logic signed [17:0] v);
    logic [15:0] r;
    if (v < 18'sd0) r = 16'h0000;
    else if (v > 18'sd65535) r = 16'hffff;
    else r = v[15:0];
    return r;
  endfunction

  // negate with saturation
  function automatic logic [15:0] negsat(input logic [15:0] v);
    return (v == 16'h8000) ? 16'h7fff : 16'(-v);
  endfunction

  // wall reflection of one axis, returns {position, velocity}
  function automatic logic [31:0] wall_axis(input logic [15:0] p,
                                            input logic [15:0] v,
                                            input logic [15:0] wall);
    logic [15:0] pn;
    logic [15:0] vn;
    pn = p;
    vn = v;
    if (p == 16'd0) begin
      vn = negsat(vn);
      pn = 16'd0;
    end
    if (p >= wall) begin
      vn = negsat(vn);
      pn = wall;
    end
    return {pn, vn};
  endfunction

endpackage
`default_nettype wire

### hw/rtl/particle_group_force_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// particle_group_force_step
// Three groups of particles with position and velocity stores; write, read
// and run-rule requests over a start/busy command port.
// ---------------------------------------------------------------------------
// After reset the block clears the velocity store with busy high;
// configuration writes are taken during that time. A request is
// taken when start is high and busy low, and every request gives exactly one
// result word, shown for one cycle with out_valid; the receiver cannot stall
// it, so it must take it then. In a run, each pair inside the cutoff goes
// through the square root and then the divider, one after the other; a
// pair outside the cutoff skips both.
// ---------------------------------------------------------------------------
module particle_group_force_step (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [1:0]         in_first_group,
  input  wire logic [1:0]         in_second_group,
  input  wire logic [7:0]         in_particle_index,
  input  wire logic [15:0]        in_new_x,
  input  wire logic [15:0]        in_new_y,
  input  wire logic signed [15:0] in_gain,
  output logic                    out_valid,
  output logic [1:0]              out_ack_kind,
  output logic [15:0]             out_pos_x,
  output logic [15:0]             out_pos_y,
  output logic signed [15:0]      out_vel_x,
  output logic signed [15:0]      out_vel_y
);

  pgfs_pkg::pgfs_cmd_t  cmd;
  pgfs_pkg::pgfs_stat_t stat;

  // sequencing
  pgfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // stores and arithmetic
  pgfs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_first_group    (in_first_group),
    .in_second_group   (in_second_group),
    .in_particle_index (in_particle_index),
    .in_new_x          (in_new_x),
    .in_new_y          (in_new_y),
    .in_gain           (in_gain),
    .out_ack_kind      (out_ack_kind),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_vel_x         (out_vel_x),
    .out_vel_y         (out_vel_y)
  );

endmodule
`default_nettype wire

### hw/rtl/pgfs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_ram
// Generic single write port, single read port memory with registered read.
// ---------------------------------------------------------------------------
module pgfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/pgfs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_sqrt
// Floor integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module pgfs_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [pgfs_pkg::DSQ_W-1:0] din,
  output logic                            done,
  output logic      [pgfs_pkg::ROOT_W-1:0] root
);

  localparam int STEPS = pgfs_pkg::DSQ_W / 2;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int RW    = pgfs_pkg::ROOT_W + 2;

  logic [RW-1:0]                rem_r, rem_nxt;
  logic [pgfs_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [pgfs_pkg::DSQ_W-1:0]   val_r, val_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [RW+1:0]                rem_sh;
  logic [RW+1:0]                trial;

  // one digit step
  always_comb begin
    rem_sh   = {rem_r, val_r[pgfs_pkg::DSQ_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      val_nxt  = din;
      cnt_nxt  = CW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= trial) begin
        rem_nxt  = RW'(rem_sh - trial);
        root_nxt = {root_r[pgfs_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = RW'(rem_sh);
        root_nxt = {root_r[pgfs_pkg::ROOT_W-2:0], 1'b0};
      end
      val_nxt = {val_r[pgfs_pkg::DSQ_W-3:0], 2'b00};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    val_r  <= val_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

### hw/rtl/pgfs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_div
// Signed by unsigned restoring divider, truncating toward zero, one quotient
// bit per cycle. The numerator magnitude is below den * 2^16.
// ---------------------------------------------------------------------------
module pgfs_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic signed [pgfs_pkg::NUM_W-1:0]  num,
  input  wire logic        [pgfs_pkg::ROOT_W-1:0] den,
  output logic                                    done,
  output logic signed      [pgfs_pkg::QUO_W-1:0]  quo
);

  localparam int QW    = pgfs_pkg::QUO_W - 1;
  localparam int STEPS = QW;
  localparam int CW    = $clog2(STEPS + 1);
  localparam int DW    = pgfs_pkg::ROOT_W;

  logic                       neg_r, neg_nxt;
  logic [DW-1:0]              rem_r, rem_nxt;
  logic [QW-1:0]              low_r, low_nxt;
  logic [QW-1:0]              q_r, q_nxt;
  logic [DW-1:0]              den_r, den_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pgfs_pkg::NUM_W-1:0] mag;
  logic [DW:0]                trial;

  // one quotient bit a cycle
  always_comb begin
    mag      = num[pgfs_pkg::NUM_W-1] ? pgfs_pkg::NUM_W'(-num) : num;
    trial    = {rem_r, low_r[QW-1]};
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      neg_nxt  = num[pgfs_pkg::NUM_W-1];
      rem_nxt  = mag[QW+DW-1:QW];
      low_nxt  = mag[QW-1:0];
      q_nxt    = '0;
      den_nxt  = den;
      cnt_nxt  = CW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = DW'(trial - {1'b0, den_r});
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = DW'(trial);
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      low_nxt = {low_r[QW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule
`default_nettype wire

### hw/rtl/pgfs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_dp
// Datapath: configuration registers, request latch, particle stores, pair
// distance and force arithmetic, velocity and position update, wall pass.
// ---------------------------------------------------------------------------
module pgfs_dp (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire pgfs_pkg::pgfs_cmd_t     cmd,
  output pgfs_pkg::pgfs_stat_t         stat,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [15:0]             cfg_wdata,
  input  wire logic [1:0]              in_req_type,
  input  wire logic [1:0]              in_first_group,
  input  wire logic [1:0]              in_second_group,
  input  wire logic [7:0]              in_particle_index,
  input  wire logic [15:0]             in_new_x,
  input  wire logic [15:0]             in_new_y,
  input  wire logic signed [15:0]      in_gain,
  output logic [1:0]                   out_ack_kind,
  output logic [15:0]                  out_pos_x,
  output logic [15:0]                  out_pos_y,
  output logic signed [15:0]           out_vel_x,
  output logic signed [15:0]           out_vel_y
);

  localparam int AW = pgfs_pkg::ADDR_W;
  localparam int CW = pgfs_pkg::CNT_W;
  localparam int GW = pgfs_pkg::GCNT_W;
  localparam int SW = pgfs_pkg::SUM_W;
  localparam int VW = pgfs_pkg::VSUM_W;

  // configuration
  logic [15:0] arena_w_r, arena_h_r, cutoff_r;
  logic [pgfs_pkg::ACT_W-1:0] active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arena_w_r <= pgfs_pkg::ARENA_W_RST;
      arena_h_r <= pgfs_pkg::ARENA_H_RST;
      cutoff_r  <= pgfs_pkg::CUTOFF_RST;
      active_r  <= pgfs_pkg::ACTIVE_RST;
    end else if (cfg_we) begin
      case (pgfs_pkg::cfg_idx_t'(cfg_index))
        pgfs_pkg::CFG_ARENA_WIDTH:  arena_w_r <= cfg_wdata;
        pgfs_pkg::CFG_ARENA_HEIGHT: arena_h_r <= cfg_wdata;
        pgfs_pkg::CFG_CUTOFF:       cutoff_r  <= cfg_wdata;
        pgfs_pkg::CFG_ACTIVE_COUNT: active_r  <= cfg_wdata[pgfs_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  logic [1:0]               req_r, ga_r, gb_r;
  logic [7:0]               idx_r;
  logic [15:0]              nx_r, ny_r;
  logic signed [15:0]       gain_r;
  logic [CW-1:0]            n_r;
  logic [pgfs_pkg::DSQ_W-1:0] lim_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r  <= in_req_type;
      ga_r   <= in_first_group;
      gb_r   <= in_second_group;
      idx_r  <= in_particle_index;
      nx_r   <= in_new_x;
      ny_r   <= in_new_y;
      gain_r <= in_gain;
      n_r    <= (32'(active_r) > pgfs_pkg::MAX_PER_GROUP) ?
                CW'(pgfs_pkg::MAX_PER_GROUP) : CW'(active_r);
      lim_r  <= cutoff_r * cutoff_r;
    end
  end

  // loop counters
  logic [CW-1:0] i_r, j_r;
  logic [GW-1:0] g_r;
  logic [AW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_inc) clr_r <= clr_r + AW'(1);
    if (cmd.i_clr) i_r <= '0;
    else if (cmd.i_inc) i_r <= i_r + CW'(1);
    if (cmd.a_latch) j_r <= '0;
    else if (cmd.j_inc) j_r <= j_r + CW'(1);
    if (cmd.g_clr) g_r <= '0;
    else if (cmd.g_inc) g_r <= g_r + GW'(1);
  end

  // addresses
  logic [AW-1:0] addr_req, addr_a, addr_b, addr_w, raddr, waddr;
  assign addr_req = pgfs_pkg::addr_of(4'(ga_r), idx_r[pgfs_pkg::IDX_W-1:0]);
  assign addr_a   = pgfs_pkg::addr_of(4'(ga_r), i_r[pgfs_pkg::IDX_W-1:0]);
  assign addr_b   = pgfs_pkg::addr_of(4'(gb_r), j_r[pgfs_pkg::IDX_W-1:0]);
  assign addr_w   = pgfs_pkg::addr_of(4'(g_r),  i_r[pgfs_pkg::IDX_W-1:0]);

  always_comb begin
    case (cmd.rd_sel)
      pgfs_pkg::SEL_REQ:  raddr = addr_req;
      pgfs_pkg::SEL_A:    raddr = addr_a;
      pgfs_pkg::SEL_B:    raddr = addr_b;
      pgfs_pkg::SEL_WALL: raddr = addr_w;
      default:            raddr = addr_req;
    endcase
  end

  // stores: position {x, y} and velocity {vx, vy}
  logic [31:0] pos_rd, vel_rd, pos_wd, vel_wd;

  pgfs_ram #(.WIDTH(32), .DEPTH(pgfs_pkg::STORE_DEPTH)) u_pos_ram (
    .clk   (clk),
    .we    (cmd.pos_we),
    .waddr (waddr),
    .wdata (pos_wd),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (pos_rd)
  );

  pgfs_ram #(.WIDTH(32), .DEPTH(pgfs_pkg::STORE_DEPTH)) u_vel_ram (
    .clk   (clk),
    .we    (cmd.vel_we),
    .waddr (waddr),
    .wdata (vel_wd),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (vel_rd)
  );

  // particle a
  logic [15:0] pax_r, pay_r, vax_r, vay_r;
  logic signed [SW-1:0] sum_x_r, sum_y_r;

  // pair arithmetic
  logic signed [16:0]               dx_r, dy_r;
  logic signed [33:0]               sqx_w, sqy_w;
  logic signed [pgfs_pkg::NUM_W-1:0] px_w, py_w, px_r, py_r;
  logic [31:0]                      sqx_r, sqy_r;
  logic [pgfs_pkg::DSQ_W:0]         dsq_r;
  logic [pgfs_pkg::ROOT_W-1:0]      root;
  logic signed [pgfs_pkg::QUO_W-1:0] qx, qy;
  logic                             sq_done, dx_done, dy_done;

  assign sqx_w = dx_r * dx_r;
  assign sqy_w = dy_r * dy_r;
  assign px_w  = gain_r * dx_r;
  assign py_w  = gain_r * dy_r;

  always_ff @(posedge clk) begin
    if (cmd.a_latch) begin
      pax_r   <= pos_rd[31:16];
      pay_r   <= pos_rd[15:0];
      vax_r   <= vel_rd[31:16];
      vay_r   <= vel_rd[15:0];
      sum_x_r <= '0;
      sum_y_r <= '0;
    end else if (cmd.acc) begin
      sum_x_r <= sum_x_r + SW'(qx);
      sum_y_r <= sum_y_r + SW'(qy);
    end
    if (cmd.diff) begin
      dx_r <= $signed({1'b0, pax_r}) - $signed({1'b0, pos_rd[31:16]});
      dy_r <= $signed({1'b0, pay_r}) - $signed({1'b0, pos_rd[15:0]});
    end
    if (cmd.mult) begin
      sqx_r <= sqx_w[31:0];
      sqy_r <= sqy_w[31:0];
      px_r  <= px_w;
      py_r  <= py_w;
    end
    if (cmd.dsum) dsq_r <= {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  pgfs_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .din   (dsq_r[pgfs_pkg::DSQ_W-1:0]),
    .done  (sq_done),
    .root  (root)
  );

  pgfs_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (px_r),
    .den   (root),
    .done  (dx_done),
    .quo   (qx)
  );

  pgfs_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (py_r),
    .den   (root),
    .done  (dy_done),
    .quo   (qy)
  );

  // velocity update: (v*256 + sum) / 512 toward zero, then clamp
  logic signed [VW-1:0] vsx, vsy, vax_adj, vay_adj;
  logic [15:0]          vnx_r, vny_r;

  always_comb begin
    vsx = $signed({{(VW-24){vax_r[15]}}, vax_r, 8'd0}) + VW'(sum_x_r);
    vsy = $signed({{(VW-24){vay_r[15]}}, vay_r, 8'd0}) + VW'(sum_y_r);
    vax_adj = vsx[VW-1] ? vsx + VW'(511) : vsx;
    vay_adj = vsy[VW-1] ? vsy + VW'(511) : vsy;
  end

  always_ff @(posedge clk) begin
    if (cmd.vel_calc) begin
      vnx_r <= pgfs_pkg::sat16(18'(vax_adj >>> 9));
      vny_r <= pgfs_pkg::sat16(18'(vay_adj >>> 9));
    end
  end

  // move and wall results
  logic [15:0] mvx, mvy;
  logic [31:0] wx, wy;

  always_comb begin
    mvx = pgfs_pkg::satpos($signed({2'b00, pax_r}) + $signed({{2{vnx_r[15]}}, vnx_r}));
    mvy = pgfs_pkg::satpos($signed({2'b00, pay_r}) + $signed({{2{vny_r[15]}}, vny_r}));
    wx  = pgfs_pkg::wall_axis(pos_rd[31:16], vel_rd[31:16], arena_w_r);
    wy  = pgfs_pkg::wall_axis(pos_rd[15:0],  vel_rd[15:0],  arena_h_r);
  end

  // write address and data
  always_comb begin
    case (cmd.wr_sel)
      pgfs_pkg::WR_REQ: begin
        waddr  = addr_req;
        pos_wd = {nx_r, ny_r};
        vel_wd = '0;
      end
      pgfs_pkg::WR_MOVE: begin
        waddr  = addr_a;
        pos_wd = {mvx, mvy};
        vel_wd = {vnx_r, vny_r};
      end
      pgfs_pkg::WR_WALL: begin
        waddr  = addr_w;
        pos_wd = {wx[31:16], wy[31:16]};
        vel_wd = {wx[15:0], wy[15:0]};
      end
      pgfs_pkg::WR_CLEAR: begin
        waddr  = clr_r;
        pos_wd = '0;
        vel_wd = '0;
      end
      default: begin
        waddr  = clr_r;
        pos_wd = '0;
        vel_wd = '0;
      end
    endcase
  end

  // read result word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      out_pos_x <= '0;
      out_pos_y <= '0;
      out_vel_x <= '0;
      out_vel_y <= '0;
    end else if (cmd.capture) begin
      out_pos_x <= pos_rd[31:16];
      out_pos_y <= pos_rd[15:0];
      out_vel_x <= vel_rd[31:16];
      out_vel_y <= vel_rd[15:0];
    end
  end

  assign out_ack_kind = req_r;

  // status
  always_comb begin
    stat.req       = pgfs_pkg::req_t'(req_r);
    stat.addr_ok   = (32'(ga_r) < pgfs_pkg::GROUP_COUNT) &&
                     (32'(idx_r) < pgfs_pkg::MAX_PER_GROUP);
    stat.groups_ok = (32'(ga_r) < pgfs_pkg::GROUP_COUNT) &&
                     (32'(gb_r) < pgfs_pkg::GROUP_COUNT);
    stat.i_end     = (i_r == n_r);
    stat.j_end     = (j_r == n_r);
    stat.g_end     = (g_r == GW'(pgfs_pkg::GROUP_COUNT));
    stat.clr_last  = (clr_r == AW'(pgfs_pkg::STORE_DEPTH - 1));
    stat.in_range  = (dsq_r != '0) && (dsq_r < {1'b0, lim_r});
    stat.sqrt_done = sq_done;
    stat.div_done  = dx_done & dy_done;
  end

endmodule
`default_nettype wire

### hw/rtl/pgfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pgfs_ctrl
// Controller: velocity clear after reset, request dispatch, force pass over
// particle pairs, wall pass, result strobe.
// ---------------------------------------------------------------------------
module pgfs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire pgfs_pkg::pgfs_stat_t stat,
  output pgfs_pkg::pgfs_cmd_t       cmd,
  output logic                      busy,
  output logic                      out_valid
);

  typedef enum logic [17:0] {
    S_CLEAR    = 18'h00001,
    S_IDLE     = 18'h00002,
    S_DISPATCH = 18'h00004,
    S_RD_WAIT  = 18'h00008,
    S_DONE     = 18'h00010,
    S_A_CHECK  = 18'h00020,
    S_A_LATCH  = 18'h00040,
    S_B_CHECK  = 18'h00080,
    S_B_WAIT   = 18'h00100,
    S_MUL      = 18'h00200,
    S_SUM      = 18'h00400,
    S_TEST     = 18'h00800,
    S_SQRT     = 18'h01000,
    S_DIV      = 18'h02000,
    S_VEL      = 18'h04000,
    S_MOVE     = 18'h08000,
    S_W_CHECK  = 18'h10000,
    S_W_WAIT   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.vel_we  = 1'b1;
        cmd.wr_sel  = pgfs_pkg::WR_CLEAR;
        cmd.clr_inc = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.req)
          pgfs_pkg::REQ_WRITE: begin
            cmd.pos_we = stat.addr_ok;
            cmd.vel_we = stat.addr_ok;
            cmd.wr_sel = pgfs_pkg::WR_REQ;
            state_nxt  = S_DONE;
          end
          pgfs_pkg::REQ_READ: begin
            cmd.rd_en  = stat.addr_ok;
            cmd.rd_sel = pgfs_pkg::SEL_REQ;
            state_nxt  = S_RD_WAIT;
          end
          pgfs_pkg::REQ_RUN: begin
            cmd.i_clr = 1'b1;
            state_nxt = stat.groups_ok ? S_A_CHECK : S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD_WAIT: begin
        cmd.capture = stat.addr_ok;
        state_nxt   = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      // force pass, particle a
      S_A_CHECK: begin
        if (stat.i_end) begin
          cmd.i_clr = 1'b1;
          cmd.g_clr = 1'b1;
          state_nxt = S_W_CHECK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pgfs_pkg::SEL_A;
          state_nxt  = S_A_LATCH;
        end
      end
      S_A_LATCH: begin
        cmd.a_latch = 1'b1;
        state_nxt   = S_B_CHECK;
      end
      // particle b of the source group
      S_B_CHECK: begin
        if (stat.j_end) begin
          state_nxt = S_VEL;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pgfs_pkg::SEL_B;
          state_nxt  = S_B_WAIT;
        end
      end
      S_B_WAIT: begin
        cmd.diff  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mult  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.dsum  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.in_range) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = S_SQRT;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_B_CHECK;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.acc   = 1'b1;
          cmd.j_inc = 1'b1;
          state_nxt = S_B_CHECK;
        end
      end
      // update of particle a
      S_VEL: begin
        cmd.vel_calc = 1'b1;
        state_nxt    = S_MOVE;
      end
      S_MOVE: begin
        cmd.pos_we = 1'b1;
        cmd.vel_we = 1'b1;
        cmd.wr_sel = pgfs_pkg::WR_MOVE;
        cmd.i_inc  = 1'b1;
        state_nxt  = S_A_CHECK;
      end
      // wall pass over every group
      S_W_CHECK: begin
        if (stat.g_end) begin
          state_nxt = S_DONE;
        end else if (stat.i_end) begin
          cmd.i_clr = 1'b1;
          cmd.g_inc = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pgfs_pkg::SEL_WALL;
          state_nxt  = S_W_WAIT;
        end
      end
      S_W_WAIT: begin
        cmd.pos_we = 1'b1;
        cmd.vel_we = 1'b1;
        cmd.wr_sel = pgfs_pkg::WR_WALL;
        cmd.i_inc  = 1'b1;
        state_nxt  = S_W_CHECK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule
`default_nettype wire

### verif/particle_group_force_step_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// particle_group_force_step_tb
// Drives write, read, run-rule and unknown requests into the particle
// store under several arena, cutoff and active-count settings, predicts
// every result word with a fixed-point model of the force and wall passes
// and compares each word field by field.
// ---------------------------------------------------------------------------
module particle_group_force_step_tb;

  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct {
    pgfs_pkg::req_t kind;
    logic [1:0]  grp_a;
    logic [1:0]  grp_b;
    logic [7:0]  idx;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] gain;
  } request_t;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] vx;
    logic [15:0] vy;
  } reply_t;

  // ---------------------------------------------------------------------
  // particle store model and queue of expected reply words
  // ---------------------------------------------------------------------
  class particle_scoreboard;
    int unsigned arena_w, arena_h, cutoff, active;
    int unsigned pos_x[pgfs_pkg::STORE_DEPTH];
    int unsigned pos_y[pgfs_pkg::STORE_DEPTH];
    int vel_x[pgfs_pkg::STORE_DEPTH];
    int vel_y[pgfs_pkg::STORE_DEPTH];
    reply_t expected_replies[$];
    int mismatches;
    int replies_seen;
    int runs_seen;

    function new();
      arena_w = 64000;
      arena_h = 64000;
      cutoff = 5120;
      active = 200;
      mismatches = 0;
      replies_seen = 0;
      runs_seen = 0;
      for (int k = 0; k < pgfs_pkg::STORE_DEPTH; k++) begin
        pos_x[k] = 0;
        pos_y[k] = 0;
        vel_x[k] = 0;
        vel_y[k] = 0;
      end
    endfunction

    function void set_register(pgfs_pkg::cfg_idx_t idx, int unsigned val);
      case (idx)
        pgfs_pkg::CFG_ARENA_WIDTH:  arena_w = val & 16'hffff;
        pgfs_pkg::CFG_ARENA_HEIGHT: arena_h = val & 16'hffff;
        pgfs_pkg::CFG_CUTOFF:       cutoff = val & 16'hffff;
        pgfs_pkg::CFG_ACTIVE_COUNT: active = val & 9'h1ff;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function int clamp_vel(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function int unsigned clamp_pos(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return int'(v);
    endfunction

    function int unsigned used_count();
      return (active > pgfs_pkg::MAX_PER_GROUP) ? pgfs_pkg::MAX_PER_GROUP : active;
    endfunction

    // force of group gb on group ga, in index order
    function void apply_forces(int ga, int gb, longint g);
      int unsigned n;
      longint lim, dx, dy, dsq, d, fx, fy;
      int ia, ib, vx, vy;
      n = used_count();
      lim = longint'(cutoff) * longint'(cutoff);
      for (int i = 0; i < n; i++) begin
        ia = ga * pgfs_pkg::MAX_PER_GROUP + i;
        fx = 0;
        fy = 0;
        for (int j = 0; j < n; j++) begin
          ib = gb * pgfs_pkg::MAX_PER_GROUP + j;
          dx = longint'(pos_x[ia]) - longint'(pos_x[ib]);
          dy = longint'(pos_y[ia]) - longint'(pos_y[ib]);
          dsq = dx * dx + dy * dy;
          if (dsq > 0 && dsq < lim) begin
            d = longint'(int_sqrt(dsq));
            fx += (g * dx) / d;
            fy += (g * dy) / d;
          end
        end
        vx = clamp_vel((longint'(vel_x[ia]) * 256 + fx) / 512);
        vy = clamp_vel((longint'(vel_y[ia]) * 256 + fy) / 512);
        vel_x[ia] = vx;
        vel_y[ia] = vy;
        pos_x[ia] = clamp_pos(longint'(pos_x[ia]) + vx);
        pos_y[ia] = clamp_pos(longint'(pos_y[ia]) + vy);
      end
    endfunction

    // reflect one axis off its walls, compares use the old position
    function void reflect(inout int unsigned p, inout int v, input int unsigned wall);
      int unsigned orig;
      orig = p;
      if (orig == 0) begin
        v = clamp_vel(-longint'(v));
        p = 0;
      end
      if (orig >= wall) begin
        v = clamp_vel(-longint'(v));
        p = wall;
      end
    endfunction

    function void wall_bounce();
      int k;
      for (int g = 0; g < pgfs_pkg::GROUP_COUNT; g++) begin
        for (int i = 0; i < used_count(); i++) begin
          k = g * pgfs_pkg::MAX_PER_GROUP + i;
          reflect(pos_x[k], vel_x[k], arena_w);
          reflect(pos_y[k], vel_y[k], arena_h);
        end
      end
    endfunction

    // update the model for an accepted request and queue its reply
    function void note_request(request_t rq);
      reply_t rp;
      bit addr_ok;
      int k;
      addr_ok = rq.grp_a < pgfs_pkg::GROUP_COUNT;
      k = rq.grp_a * pgfs_pkg::MAX_PER_GROUP + rq.idx;
      rp.kind = rq.kind;
      rp.px = '0;
      rp.py = '0;
      rp.vx = '0;
      rp.vy = '0;
      case (rq.kind)
        pgfs_pkg::REQ_WRITE: if (addr_ok) begin
          pos_x[k] = rq.nx;
          pos_y[k] = rq.ny;
          vel_x[k] = 0;
          vel_y[k] = 0;
        end
        pgfs_pkg::REQ_READ: if (addr_ok) begin
          rp.px = pos_x[k][15:0];
          rp.py = pos_y[k][15:0];
          rp.vx = vel_x[k][15:0];
          rp.vy = vel_y[k][15:0];
        end
        pgfs_pkg::REQ_RUN: if (rq.grp_a < pgfs_pkg::GROUP_COUNT &&
                               rq.grp_b < pgfs_pkg::GROUP_COUNT) begin
          apply_forces(rq.grp_a, rq.grp_b, longint'($signed(rq.gain)));
          wall_bounce();
          runs_seen++;
        end
        default: ;
      endcase
      expected_replies = {expected_replies, rp};
    endfunction

    function void check_reply(reply_t got);
      reply_t exp_rp;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("reply word with nothing expected: kind %0d", got.kind);
        mismatches++;
        return;
      end
      exp_rp = expected_replies.pop_front();
      if (got.kind !== exp_rp.kind) begin
        $error("ack_kind: expected %0d, got %0d", exp_rp.kind, got.kind);
        mismatches++;
      end
      if (got.px !== exp_rp.px) begin
        $error("pos_x: expected %0d, got %0d", exp_rp.px, got.px);
        mismatches++;
      end
      if (got.py !== exp_rp.py) begin
        $error("pos_y: expected %0d, got %0d", exp_rp.py, got.py);
        mismatches++;
      end
      if (got.vx !== exp_rp.vx) begin
        $error("vel_x: expected %0d, got %0d", $signed(exp_rp.vx), $signed(got.vx));
        mismatches++;
      end
      if (got.vy !== exp_rp.vy) begin
        $error("vel_y: expected %0d, got %0d", $signed(exp_rp.vy), $signed(got.vy));
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_req_type = '0;
  logic [1:0] in_first_group = '0;
  logic [1:0] in_second_group = '0;
  logic [7:0] in_particle_index = '0;
  logic [15:0] in_new_x = '0;
  logic [15:0] in_new_y = '0;
  logic signed [15:0] in_gain = '0;
  logic out_valid;
  logic [1:0] out_ack_kind;
  logic [15:0] out_pos_x;
  logic [15:0] out_pos_y;
  logic signed [15:0] out_vel_x;
  logic signed [15:0] out_vel_y;

  particle_scoreboard sb = new();
  bit written[pgfs_pkg::STORE_DEPTH];
  int idle_pct = 0;
  int requests_sent = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  particle_group_force_step i_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy,
    .in_req_type, .in_first_group, .in_second_group, .in_particle_index,
    .in_new_x, .in_new_y, .in_gain,
    .out_valid, .out_ack_kind, .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y
  );

  // reply word monitor
  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_valid) begin
      got.kind = out_ack_kind;
      got.px = out_pos_x;
      got.py = out_pos_y;
      got.vx = out_vel_x;
      got.vy = out_vel_y;
      sb.check_reply(got);
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("particle_group_force_step regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(pgfs_pkg::cfg_idx_t idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[15:0];
    sb.set_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // present one request and hold it until taken; called at a falling edge
  task automatic send(request_t rq);
    in_req_type = rq.kind;
    in_first_group = rq.grp_a;
    in_second_group = rq.grp_b;
    in_particle_index = rq.idx;
    in_new_x = rq.nx;
    in_new_y = rq.ny;
    in_gain = rq.gain;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(rq);
    requests_sent++;
    if (rq.kind == pgfs_pkg::REQ_WRITE && rq.grp_a < pgfs_pkg::GROUP_COUNT)
      written[rq.grp_a * pgfs_pkg::MAX_PER_GROUP + rq.idx] = 1'b1;
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic request_t make_req(pgfs_pkg::req_t kind, int ga, int gb, int idx,
                                        int unsigned nx, int unsigned ny, int gain);
    request_t rq;
    rq.kind = kind;
    rq.grp_a = ga[1:0];
    rq.grp_b = gb[1:0];
    rq.idx = idx[7:0];
    rq.nx = nx[15:0];
    rq.ny = ny[15:0];
    rq.gain = gain[15:0];
    return rq;
  endfunction

  // positions mostly in one cluster so that pairs fall inside the cutoff
  function automatic int unsigned coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 30000 + $urandom_range(0, 3000);
    if (r < 85) return $urandom_range(0, 300);
    return 65535 - $urandom_range(0, 300);
  endfunction

  function automatic int rand_gain();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  task automatic settle();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic setup_particles(int n);
    for (int g = 0; g < pgfs_pkg::GROUP_COUNT; g++)
      for (int i = 0; i < n; i++)
        send(make_req(pgfs_pkg::REQ_WRITE, g, 0, i, coord(), coord(), 0));
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned c, int unsigned n);
    settle();
    write_reg(pgfs_pkg::CFG_ARENA_WIDTH, w);
    write_reg(pgfs_pkg::CFG_ARENA_HEIGHT, h);
    write_reg(pgfs_pkg::CFG_CUTOFF, c);
    write_reg(pgfs_pkg::CFG_ACTIVE_COUNT, n);
  endtask

  task automatic random_requests(int count);
    int r, g, i, n;
    request_t rq;
    n = sb.used_count();
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      g = ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2);
      if (r < 38) begin
        i = ($urandom_range(0, 9) < 7) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
        rq = make_req(pgfs_pkg::REQ_WRITE, g, $urandom_range(0, 3), i, coord(),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      end else if (r < 72) begin
        i = $urandom_range(0, 255);
        if (g < pgfs_pkg::GROUP_COUNT && !written[g * pgfs_pkg::MAX_PER_GROUP + i])
          i = $urandom_range(0, n - 1);
        rq = make_req(pgfs_pkg::REQ_READ, g, $urandom_range(0, 3), i,
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
      end else if (r < 92) begin
        rq = make_req(pgfs_pkg::REQ_RUN, g,
                      ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                      $urandom_range(0, 255), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), rand_gain());
      end else begin
        rq = make_req(pgfs_pkg::REQ_OTHER, $urandom_range(0, 3), $urandom_range(0, 3),
                      $urandom_range(0, 255), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535));
      end
      send(rq);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed checks with defaults on the walls and a small group
    idle_pct = 25;
    configure(64000, 64000, 5120, 4);
    setup_particles(4);
    send(make_req(pgfs_pkg::REQ_WRITE, 0, 0, 0, 0, 65535, 0));
    send(make_req(pgfs_pkg::REQ_WRITE, 2, 0, 255, 65535, 0, 0));
    send(make_req(pgfs_pkg::REQ_WRITE, 1, 0, 1, 30100, 30100, 0));
    send(make_req(pgfs_pkg::REQ_WRITE, 2, 0, 1, 30100, 30100, 0));
    send(make_req(pgfs_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    send(make_req(pgfs_pkg::REQ_READ, 2, 0, 255, 0, 0, 0));
    send(make_req(pgfs_pkg::REQ_WRITE, 3, 0, 7, 1234, 4321, 0));
    send(make_req(pgfs_pkg::REQ_READ, 3, 0, 7, 0, 0, 0));
    send(make_req(pgfs_pkg::REQ_OTHER, 3, 3, 255, 65535, 65535, -1));
    send(make_req(pgfs_pkg::REQ_RUN, 0, 1, 0, 0, 0, 16384));
    send(make_req(pgfs_pkg::REQ_RUN, 1, 2, 0, 0, 0, -16384));
    send(make_req(pgfs_pkg::REQ_RUN, 2, 2, 0, 0, 0, 0));
    send(make_req(pgfs_pkg::REQ_RUN, 3, 0, 0, 0, 0, 16384));
    send(make_req(pgfs_pkg::REQ_RUN, 0, 3, 0, 0, 0, 16384));
    send(make_req(pgfs_pkg::REQ_RUN, 1, 1, 0, 0, 0, -16384));
    for (int g = 0; g < pgfs_pkg::GROUP_COUNT; g++)
      send(make_req(pgfs_pkg::REQ_READ, g, 0, 1, 0, 0, 0));
    send(make_req(pgfs_pkg::REQ_READ, 0, 0, 0, 0, 0, 0));
    random_requests(15);

    // widest arena, zero height wall, largest cutoff
    idle_pct = 53;
    configure(65535, 0, 65535, 6);
    setup_particles(6);
    random_requests(12);

    // no pair inside the cutoff, narrow arena
    idle_pct = 0;
    configure(1000, 40000, 0, 6);
    send(make_req(pgfs_pkg::REQ_RUN, 2, 0, 0, 0, 0, -16384));
    for (int k = 0; k < 6; k++)
      send(make_req(pgfs_pkg::REQ_READ, $urandom_range(0, 2), 0, $urandom_range(0, 5),
                    0, 0, 0));

    // tight cutoff, steady sender
    configure(50000, 50000, 2000, 5);
    random_requests(12);

    settle();
    repeat (20) @(negedge clk);
    $display("covered %0d requests, %0d force passes, %0d reply words checked",
             requests_sent, sb.runs_seen, sb.replies_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("particle_group_force_step regression: pass");
    end else begin
      $display("particle_group_force_step regression: fail");
    end
    $finish;
  end

endmodule

### particle_group_force_step.f
hw/rtl/pgfs_pkg.sv
hw/rtl/pgfs_ram.sv
hw/rtl/pgfs_sqrt.sv
hw/rtl/pgfs_div.sv
hw/rtl/pgfs_dp.sv
hw/rtl/pgfs_ctrl.sv
hw/rtl/particle_group_force_step.sv
verif/particle_group_force_step_tb.sv
